// ===== hw/rtl/clma_pkg.sv =====
// Package: request/result types and fixed constants for the CPU load averager.
`default_nettype none

package clma_pkg;

    localparam int LOAD_W   = 8;   // signed CPU load on the input
    localparam int KERN_W   = 7;   // kernel load on the input
    localparam int AVG_W    = 7;   // stored entry and mean width
    localparam int PHASE_W  = 3;   // grid phase output width
    localparam int WIN_W    = 6;   // window length register width
    localparam int SUM_W    = 13;  // 63 entries of 7 bits
    localparam int LANES    = 4;   // cpu0, cpu1, kernel0, kernel1
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_ENABLE = 1'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd8;
    localparam logic [WIN_W-1:0] WINDOW_MAX   = 6'd63;

    localparam int LANE_CPU0  = 0;
    localparam int LANE_CPU1  = 1;
    localparam int LANE_KERN0 = 2;
    localparam int LANE_KERN1 = 3;

    typedef struct packed {
        logic signed [LOAD_W-1:0] cpu0_load;
        logic signed [LOAD_W-1:0] cpu1_load;
        logic [KERN_W-1:0]        cpu0_kernel;
        logic [KERN_W-1:0]        cpu1_kernel;
    } clma_in_t;

    typedef struct packed {
        logic [AVG_W-1:0]   avg_cpu0;
        logic [AVG_W-1:0]   avg_cpu1;
        logic [AVG_W-1:0]   avg_kernel0;
        logic [AVG_W-1:0]   avg_kernel1;
        logic [PHASE_W-1:0] grid_phase;
    } clma_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module clma_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/clma_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient known to fit in AVG_W bits.
`default_nettype none

module clma_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [clma_pkg::SUM_W-1:0] dividend,
    input  wire logic [clma_pkg::WIN_W-1:0] divisor,
    output logic      [clma_pkg::AVG_W-1:0] quotient,
    output logic                           done
);

    localparam int CNT_W = $clog2(clma_pkg::AVG_W);

    logic [clma_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [clma_pkg::SUM_W-1:0] dvs_reg, dvs_next;
    logic [clma_pkg::AVG_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       ge;

    assign ge = (rem_reg >= dvs_reg);

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            // divisor aligned to the top quotient bit
            dvs_next  = clma_pkg::SUM_W'({divisor, {(clma_pkg::AVG_W-1){1'b0}}});
            quo_next  = '0;
            cnt_next  = CNT_W'(clma_pkg::AVG_W-1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dvs_reg;
            end
            quo_next = {quo_reg[clma_pkg::AVG_W-2:0], ge};
            dvs_next = dvs_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_load_moving_average_unit.sv =====
// Top level: CPU and kernel load moving average over a RAM-held history.
// Each result waits on the single read port walking the newest n history rows and a
//   7-step divider, n = min(fill, window_length) <= 63.
// Requests are taken only in idle; the block stays idle after a dropped (negative) one.
// Reset (aresetn, synchronous, active low) clears pointers, counts, phase and config;
//   load history is not cleared, kernel history reads as zero through a kernel fill count.
`default_nettype none

module cpu_load_moving_average_unit #(
    parameter int HISTORY       = 64,
    parameter int SCROLL_PERIOD = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [clma_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [clma_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample requests
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire clma_pkg::clma_in_t                 s_data,
    // averaged results
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output clma_pkg::clma_out_t                     m_data
);

    localparam int AW     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int FW     = AW;   // fill saturates at HISTORY-1
    localparam int PW     = (SCROLL_PERIOD > 1) ? $clog2(SCROLL_PERIOD) : 1;
    localparam int KC_MAX = (HISTORY < 63) ? HISTORY : 63;
    localparam int RAM_W  = 2 * clma_pkg::AVG_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a request
    localparam logic [2:0] ST_WALK = 3'd1;  // issue one history read per cycle
    localparam logic [2:0] ST_LAST = 3'd2;  // last read data accumulates
    localparam logic [2:0] ST_DIVS = 3'd3;  // kick the dividers
    localparam logic [2:0] ST_DIV  = 3'd4;  // wait for the quotients
    localparam logic [2:0] ST_OUT  = 3'd5;  // hand over to the output register

    logic [2:0] state_reg, state_next;

    // configuration
    logic [clma_pkg::WIN_W-1:0] window_reg;
    logic                       kern_en_reg;

    // history pointers and counts
    logic [AW-1:0]              load_wr_reg, load_wr_next;
    logic [AW-1:0]              kern_wr_reg, kern_wr_next;
    logic [AW-1:0]              ld_rp_reg, ld_rp_next;
    logic [AW-1:0]              kn_rp_reg, kn_rp_next;
    logic [FW-1:0]              fill_reg, fill_next;
    logic [clma_pkg::WIN_W-1:0] kern_cnt_reg, kern_cnt_next;
    logic [PW-1:0]              phase_reg, phase_next;

    // walk control
    logic [clma_pkg::WIN_W-1:0] n_reg, n_next;
    logic [clma_pkg::WIN_W-1:0] left_reg, left_next;
    logic [clma_pkg::WIN_W-1:0] kleft_reg, kleft_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic                       kv_reg, kv_next;

    logic [clma_pkg::SUM_W-1:0] sum_reg  [clma_pkg::LANES];
    logic [clma_pkg::SUM_W-1:0] sum_next [clma_pkg::LANES];
    logic [clma_pkg::AVG_W-1:0] lane_data [clma_pkg::LANES];
    logic [clma_pkg::AVG_W-1:0] quo [clma_pkg::LANES];
    logic [clma_pkg::LANES-1:0] div_done_w;
    logic                       div_done;
    logic                       div_start;

    // output register
    logic                       m_valid_reg, m_valid_next;
    clma_pkg::clma_out_t        m_data_reg, m_data_next;

    logic                       accept;
    logic                       sample_ok;
    logic                       wr_load, wr_kern;
    logic [RAM_W-1:0]           ld_rd, kn_rd;
    logic [FW-1:0]              fill_inc;
    logic                       out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign sample_ok = !s_data.cpu0_load[clma_pkg::LOAD_W-1]
                    && !s_data.cpu1_load[clma_pkg::LOAD_W-1];
    assign wr_load   = accept && sample_ok;
    assign wr_kern   = wr_load && kern_en_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == ST_DIVS);
    assign div_done  = &div_done_w;

    // ------------------------------------------------------------------
    // History stores: one row holds both channels of a pair
    // ------------------------------------------------------------------
    clma_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HISTORY)
    ) u_load_ram (
        .aclk    (aclk),
        .wr_en   (wr_load),
        .wr_addr (load_wr_reg),
        .wr_data ({s_data.cpu0_load[clma_pkg::AVG_W-1:0],
                   s_data.cpu1_load[clma_pkg::AVG_W-1:0]}),
        .rd_addr (ld_rp_reg),
        .rd_data (ld_rd)
    );

    clma_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HISTORY)
    ) u_kern_ram (
        .aclk    (aclk),
        .wr_en   (wr_kern),
        .wr_addr (kern_wr_reg),
        .wr_data ({s_data.cpu0_kernel, s_data.cpu1_kernel}),
        .rd_addr (kn_rp_reg),
        .rd_data (kn_rd)
    );

    // kernel rows beyond the kernel fill count were never written: read as zero
    assign lane_data[clma_pkg::LANE_CPU0]  = ld_rd[RAM_W-1:clma_pkg::AVG_W];
    assign lane_data[clma_pkg::LANE_CPU1]  = ld_rd[clma_pkg::AVG_W-1:0];
    assign lane_data[clma_pkg::LANE_KERN0] = kv_reg ? kn_rd[RAM_W-1:clma_pkg::AVG_W] : '0;
    assign lane_data[clma_pkg::LANE_KERN1] = kv_reg ? kn_rd[clma_pkg::AVG_W-1:0] : '0;

    // ------------------------------------------------------------------
    // Accumulators and dividers, one per lane, run in lock step
    // ------------------------------------------------------------------
    for (genvar g = 0; g < clma_pkg::LANES; g++) begin : g_lane
        always_comb begin
            sum_next[g] = sum_reg[g];
            if (accept) begin
                sum_next[g] = '0;
            end else if (rd_vld_reg) begin
                sum_next[g] = sum_reg[g] + clma_pkg::SUM_W'(lane_data[g]);
            end
        end

        always_ff @(posedge aclk) begin
            sum_reg[g] <= sum_next[g];
        end

        clma_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (sum_reg[g]),
            .divisor  (n_reg),
            .quotient (quo[g]),
            .done     (div_done_w[g])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer and pointer update
    // ------------------------------------------------------------------
    assign fill_inc = (fill_reg == FW'(HISTORY-1)) ? fill_reg : fill_reg + 1'b1;

    always_comb begin
        state_next    = state_reg;
        load_wr_next  = load_wr_reg;
        kern_wr_next  = kern_wr_reg;
        ld_rp_next    = ld_rp_reg;
        kn_rp_next    = kn_rp_reg;
        fill_next     = fill_reg;
        kern_cnt_next = kern_cnt_reg;
        phase_next    = phase_reg;
        n_next        = n_reg;
        left_next     = left_reg;
        kleft_next    = kleft_reg;
        rd_vld_next   = 1'b0;
        kv_next       = 1'b0;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (wr_load) begin
                    // newest rows are the ones written now
                    ld_rp_next   = load_wr_reg;
                    kn_rp_next   = kern_wr_reg;
                    load_wr_next = (load_wr_reg == AW'(HISTORY-1)) ? '0
                                                                    : load_wr_reg + 1'b1;
                    if (kern_en_reg) begin
                        kern_wr_next = (kern_wr_reg == AW'(HISTORY-1)) ? '0
                                                                        : kern_wr_reg + 1'b1;
                        kern_cnt_next = (int'(kern_cnt_reg) >= KC_MAX) ? kern_cnt_reg
                                                                       : kern_cnt_reg + 1'b1;
                    end
                    fill_next  = fill_inc;
                    phase_next = (phase_reg == PW'(SCROLL_PERIOD-1)) ? '0 : phase_reg + 1'b1;
                    n_next     = (int'(fill_inc) < int'(window_reg))
                                 ? clma_pkg::WIN_W'(fill_inc) : window_reg;
                    left_next  = n_next;
                    kleft_next = kern_cnt_next;
                    state_next = (n_next == '0) ? ST_LAST : ST_WALK;
                end
            end
            ST_WALK: begin
                rd_vld_next = 1'b1;
                kv_next     = (kleft_reg != '0);
                if (kleft_reg != '0) begin
                    kleft_next = kleft_reg - 1'b1;
                end
                ld_rp_next = (ld_rp_reg == '0) ? AW'(HISTORY-1) : ld_rp_reg - 1'b1;
                kn_rp_next = (kn_rp_reg == '0) ? AW'(HISTORY-1) : kn_rp_reg - 1'b1;
                left_next  = left_reg - 1'b1;
                if (left_reg == clma_pkg::WIN_W'(1)) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    // empty window gives zero means; disabled kernel gives zero
                    m_data_next.avg_cpu0    = (n_reg != '0) ? quo[clma_pkg::LANE_CPU0] : '0;
                    m_data_next.avg_cpu1    = (n_reg != '0) ? quo[clma_pkg::LANE_CPU1] : '0;
                    m_data_next.avg_kernel0 = (n_reg != '0 && kern_en_reg)
                                              ? quo[clma_pkg::LANE_KERN0] : '0;
                    m_data_next.avg_kernel1 = (n_reg != '0 && kern_en_reg)
                                              ? quo[clma_pkg::LANE_KERN1] : '0;
                    m_data_next.grid_phase  = clma_pkg::PHASE_W'(phase_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            window_reg   <= clma_pkg::WINDOW_RESET;
            kern_en_reg  <= 1'b0;
            load_wr_reg  <= '0;
            kern_wr_reg  <= '0;
            fill_reg     <= '0;
            kern_cnt_reg <= '0;
            phase_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            kv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_wr_reg  <= load_wr_next;
            kern_wr_reg  <= kern_wr_next;
            fill_reg     <= fill_next;
            kern_cnt_reg <= kern_cnt_next;
            phase_reg    <= phase_next;
            rd_vld_reg   <= rd_vld_next;
            kv_reg       <= kv_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    clma_pkg::REG_WINDOW_LENGTH: window_reg  <= cfg_wdata;
                    clma_pkg::REG_KERNEL_ENABLE: kern_en_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        ld_rp_reg  <= ld_rp_next;
        kn_rp_reg  <= kn_rp_next;
        n_reg      <= n_next;
        left_reg   <= left_next;
        kleft_reg  <= kleft_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the CPU load moving average unit.
`timescale 1ns / 100ps

module tb_top;

    localparam int HISTORY       = 64;
    localparam int SCROLL_PERIOD = 8;
    localparam int RANDOM_REQS   = 720;     // valid (non-dropped) random requests
    localparam int SETTLE_GAP    = 100;
    localparam int CYCLE_LIMIT   = 1000000;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [clma_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [clma_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    clma_pkg::clma_in_t              s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    clma_pkg::clma_out_t             m_data;

    initial begin
        forever #5 aclk = ~aclk;
    end

    cpu_load_moving_average_unit #(
        .HISTORY       (HISTORY),
        .SCROLL_PERIOD (SCROLL_PERIOD)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the history rings, fill level,
    // grid phase and both registers.
    // ------------------------------------------------------------------
    logic [clma_pkg::AVG_W-1:0] hist_load0 [HISTORY];
    logic [clma_pkg::AVG_W-1:0] hist_load1 [HISTORY];
    logic [clma_pkg::AVG_W-1:0] hist_kern0 [HISTORY];
    logic [clma_pkg::AVG_W-1:0] hist_kern1 [HISTORY];
    int               load_ptr;
    int               kern_ptr;
    int               fill_level;
    int               grid_pos;
    int               win_len;
    bit               kern_on;

    clma_pkg::clma_out_t expected_averages [$];
    int               err_count = 0;

    // idle/stall likelihood in percent, changed per random segment
    int               send_idle_pct = 0;
    int               stall_pct     = 0;

    // Directed rows: either a register write or a request, with the
    // expected result typed in where it is obvious.
    typedef enum logic {ROW_REQ, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [clma_pkg::CFG_ADDR_W-1:0] reg_idx;
        logic [clma_pkg::CFG_DATA_W-1:0] reg_val;
        clma_pkg::clma_in_t              req;
        bit                              typed;
        clma_pkg::clma_out_t             lit;
    } dir_row_t;

    dir_row_t directed_rows [$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic reset_averager();
        for (int i = 0; i < HISTORY; i++) begin
            hist_load0[i] = '0;
            hist_load1[i] = '0;
            hist_kern0[i] = '0;
            hist_kern1[i] = '0;
        end
        load_ptr   = 0;
        kern_ptr   = 0;
        fill_level = 0;
        grid_pos   = 0;
        win_len    = int'(clma_pkg::WINDOW_RESET);
        kern_on    = 1'b0;
    endtask

    // Returns 1 and the expected averages when the request is kept; a
    // negative load on either CPU drops the request without trace.
    function automatic bit predict_averages(input clma_pkg::clma_in_t req,
                                            output clma_pkg::clma_out_t res);
        int n;
        int li;
        int ki;
        int s0;
        int s1;
        int s2;
        int s3;
        res = '0;
        if (req.cpu0_load[clma_pkg::LOAD_W-1] || req.cpu1_load[clma_pkg::LOAD_W-1])
            return 1'b0;

        hist_load0[load_ptr] = req.cpu0_load[clma_pkg::AVG_W-1:0];
        hist_load1[load_ptr] = req.cpu1_load[clma_pkg::AVG_W-1:0];
        load_ptr = (load_ptr + 1) % HISTORY;

        // kernel ring only moves while kernel mode is on
        if (kern_on) begin
            hist_kern0[kern_ptr] = req.cpu0_kernel;
            hist_kern1[kern_ptr] = req.cpu1_kernel;
            kern_ptr = (kern_ptr + 1) % HISTORY;
        end

        if (fill_level < HISTORY - 1)
            fill_level++;
        grid_pos = (grid_pos + 1) % SCROLL_PERIOD;

        n  = (fill_level < win_len) ? fill_level : win_len;
        s0 = 0;
        s1 = 0;
        s2 = 0;
        s3 = 0;
        for (int i = 0; i < n; i++) begin
            li = (load_ptr + HISTORY - 1 - i) % HISTORY;
            ki = (kern_ptr + HISTORY - 1 - i) % HISTORY;
            s0 += hist_load0[li];
            s1 += hist_load1[li];
            s2 += hist_kern0[ki];
            s3 += hist_kern1[ki];
        end
        // window of zero: all four means stay zero
        if (n != 0) begin
            res.avg_cpu0 = clma_pkg::AVG_W'(s0 / n);
            res.avg_cpu1 = clma_pkg::AVG_W'(s1 / n);
            if (kern_on) begin
                res.avg_kernel0 = clma_pkg::AVG_W'(s2 / n);
                res.avg_kernel1 = clma_pkg::AVG_W'(s3 / n);
            end
        end
        res.grid_phase = grid_pos[clma_pkg::PHASE_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // No gap with probability 100 - pct percent; else mostly short gaps, now and then a long one.
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(80, 20);
        return $urandom_range(4, 1);
    endfunction

    // Percent value, occasionally above 100 to cover the top bits.
    function automatic logic [clma_pkg::AVG_W-1:0] rand_pct();
        if ($urandom_range(6) == 0)
            return clma_pkg::AVG_W'($urandom_range(127, 101));
        return clma_pkg::AVG_W'($urandom_range(100, 0));
    endfunction

    function automatic clma_pkg::clma_in_t rand_request(input bit drop);
        clma_pkg::clma_in_t r;
        r.cpu0_load   = {1'b0, rand_pct()};
        r.cpu1_load   = {1'b0, rand_pct()};
        r.cpu0_kernel = rand_pct();
        r.cpu1_kernel = rand_pct();
        if (drop) begin
            case ($urandom_range(2))
                0: r.cpu0_load = clma_pkg::LOAD_W'(8'h80 | $urandom_range(127));
                1: r.cpu1_load = clma_pkg::LOAD_W'(8'h80 | $urandom_range(127));
                default: begin
                    r.cpu0_load = clma_pkg::LOAD_W'(8'h80 | $urandom_range(127));
                    r.cpu1_load = clma_pkg::LOAD_W'(8'h80 | $urandom_range(127));
                end
            endcase
        end
        return r;
    endfunction

    function automatic clma_pkg::clma_in_t mk_req(input int l0, input int l1,
                                                  input int k0, input int k1);
        clma_pkg::clma_in_t r;
        r.cpu0_load   = l0[clma_pkg::LOAD_W-1:0];
        r.cpu1_load   = l1[clma_pkg::LOAD_W-1:0];
        r.cpu0_kernel = k0[clma_pkg::KERN_W-1:0];
        r.cpu1_kernel = k1[clma_pkg::KERN_W-1:0];
        return r;
    endfunction

    function automatic clma_pkg::clma_out_t mk_avg(input int a0, input int a1, input int k0,
                                                   input int k1, input int ph);
        clma_pkg::clma_out_t r;
        r.avg_cpu0    = a0[clma_pkg::AVG_W-1:0];
        r.avg_cpu1    = a1[clma_pkg::AVG_W-1:0];
        r.avg_kernel0 = k0[clma_pkg::AVG_W-1:0];
        r.avg_kernel1 = k1[clma_pkg::AVG_W-1:0];
        r.grid_phase  = ph[clma_pkg::PHASE_W-1:0];
        return r;
    endfunction

    function automatic void row_req(input clma_pkg::clma_in_t req, input bit typed,
                                    input clma_pkg::clma_out_t lit);
        dir_row_t r;
        r.kind    = ROW_REQ;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.req     = req;
        r.typed   = typed;
        r.lit     = lit;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_write(input logic [clma_pkg::CFG_ADDR_W-1:0] idx,
                                      input int val);
        dir_row_t r;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val[clma_pkg::CFG_DATA_W-1:0];
        r.req     = '0;
        r.typed   = 1'b0;
        r.lit     = '0;
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks. All run from the stimulus process, always starting
    // and ending just after a rising edge.
    // ------------------------------------------------------------------
    // Register write; only issued while the block is idle.
    task automatic cfg_write(input logic [clma_pkg::CFG_ADDR_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[clma_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        if (idx == clma_pkg::REG_WINDOW_LENGTH)
            win_len = val & 'h3F;
        else if (idx == clma_pkg::REG_KERNEL_ENABLE)
            kern_on = val[0];
    endtask

    // Offer one request; valid holds until accepted. Left high on return
    // so back-to-back requests need no extra assignment in the same step.
    task automatic send_request(input clma_pkg::clma_in_t req, input bit typed,
                                input clma_pkg::clma_out_t lit);
        int                  gap;
        clma_pkg::clma_out_t res;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (predict_averages(req, res))
            expected_averages.push_back(typed ? lit : res);
    endtask

    // Hold off until every expected result has arrived.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_averages.size() != 0);
    endtask

    // Drained, plus time for a dropped request still in flight to clear.
    task automatic settle();
        drain_results();
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, with calm stretches.
    // ------------------------------------------------------------------
    initial begin
        int run;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(12, 1);
            repeat (run) @(posedge aclk);
            stall = pick_gap(stall_pct);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Scoreboard: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        clma_pkg::clma_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_averages.size() == 0) begin
                $error("unexpected result: %p", m_data);
                err_count++;
            end else begin
                want = expected_averages.pop_front();
                if (m_data.avg_cpu0 !== want.avg_cpu0) begin
                    $error("avg_cpu0: expected %0d, got %0d", want.avg_cpu0, m_data.avg_cpu0);
                    err_count++;
                end
                if (m_data.avg_cpu1 !== want.avg_cpu1) begin
                    $error("avg_cpu1: expected %0d, got %0d", want.avg_cpu1, m_data.avg_cpu1);
                    err_count++;
                end
                if (m_data.avg_kernel0 !== want.avg_kernel0) begin
                    $error("avg_kernel0: expected %0d, got %0d",
                           want.avg_kernel0, m_data.avg_kernel0);
                    err_count++;
                end
                if (m_data.avg_kernel1 !== want.avg_kernel1) begin
                    $error("avg_kernel1: expected %0d, got %0d",
                           want.avg_kernel1, m_data.avg_kernel1);
                    err_count++;
                end
                if (m_data.grid_phase !== want.grid_phase) begin
                    $error("grid_phase: expected %0d, got %0d",
                           want.grid_phase, m_data.grid_phase);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int        valid_sent;
        int        seg;
        int        batch;
        int        win;
        bit        drop;
        dir_row_t  row;

        reset_averager();

        // Directed table. Phases below assume reset values (window 8,
        // kernel mode off, phase 0).
        row_req(mk_req(0, 0, 0, 0), 1, mk_avg(0, 0, 0, 0, 1));
        row_req(mk_req(100, 100, 100, 100), 1, mk_avg(50, 50, 0, 0, 2));
        row_req(mk_req(-1, 50, 10, 10), 1, '0);              // dropped, cpu0 negative
        row_req(mk_req(60, -128, 10, 10), 1, '0);            // dropped, cpu1 negative
        row_req(mk_req(127, 127, 127, 127), 1, mk_avg(75, 75, 0, 0, 3)); // above 100
        // kernel mode switched on late: older kernel rows still zero
        row_write(clma_pkg::REG_KERNEL_ENABLE, 1);
        row_req(mk_req(10, 20, 127, 127), 1, mk_avg(59, 61, 31, 31, 4));
        row_req(mk_req(0, 0, 0, 0), 0, '0);
        row_write(clma_pkg::REG_WINDOW_LENGTH, 1);           // narrowest window
        row_req(mk_req(1, 2, 3, 4), 1, mk_avg(1, 2, 3, 4, 6));
        row_req(mk_req(127, 0, 0, 127), 1, mk_avg(127, 0, 0, 127, 7));
        row_write(clma_pkg::REG_WINDOW_LENGTH, int'(clma_pkg::WINDOW_MAX)); // widest window
        row_req(mk_req(100, 100, 100, 100), 0, '0);
        row_req(mk_req(-1, -1, 127, 127), 1, '0);            // dropped, both negative
        row_req(mk_req(55, 45, 35, 25), 0, '0);
        // window of zero: means forced to zero, phase still moves
        row_write(clma_pkg::REG_WINDOW_LENGTH, 0);
        row_req(mk_req(55, 66, 77, 88), 1, mk_avg(0, 0, 0, 0, 2));
        row_req(mk_req(127, 127, 127, 127), 1, mk_avg(0, 0, 0, 0, 3));
        // kernel mode off: kernel rings frozen, kernel means zero
        row_write(clma_pkg::REG_KERNEL_ENABLE, 0);
        row_write(clma_pkg::REG_WINDOW_LENGTH, 5);
        row_req(mk_req(100, 0, 100, 0), 0, '0);
        row_req(mk_req(64, 32, 16, 8), 0, '0);
        // back on: stale kernel rows from before feed the mean
        row_write(clma_pkg::REG_KERNEL_ENABLE, 1);
        row_req(mk_req(7, 7, 100, 100), 0, '0);
        row_req(mk_req(-128, 127, 0, 0), 1, '0);             // dropped
        row_write(clma_pkg::REG_WINDOW_LENGTH, int'(clma_pkg::WINDOW_RESET));
        row_req(mk_req(99, 1, 50, 51), 0, '0);

        // single reset at the start
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                settle();
                cfg_write(row.reg_idx, row.reg_val);
            end else begin
                send_request(row.req, row.typed, row.lit);
            end
        end

        // random part in segments; each starts idle with fresh settings
        valid_sent = 0;
        seg        = 0;
        while (valid_sent < RANDOM_REQS) begin
            settle();
            case ($urandom_range(9))
                0:       win = 1;
                1:       win = int'(clma_pkg::WINDOW_MAX);
                2:       win = 0;
                default: win = $urandom_range(63, 1);
            endcase
            cfg_write(clma_pkg::REG_WINDOW_LENGTH, win);
            cfg_write(clma_pkg::REG_KERNEL_ENABLE, $urandom_range(1));

            // quiet segments have no idling at all
            case ($urandom_range(3))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 10;
                2:       send_idle_pct = 30;
                default: send_idle_pct = 60;
            endcase
            case ($urandom_range(3))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                2:       stall_pct = 30;
                default: stall_pct = 60;
            endcase

            batch = $urandom_range(120, 40);
            for (int k = 0; k < batch; k++) begin
                // in the second segment the sender holds off mid-stream until the pipe runs dry
                if (seg == 1 && k == batch / 2)
                    drain_results();
                drop = ($urandom_range(9) == 0);
                send_request(rand_request(drop), 1'b0, '0);
                if (!drop)
                    valid_sent++;
            end
            seg++;
        end

        // wind down: everything back, then some slack for stray results
        settle();

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
